// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the converter.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, reset-qualified.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/u2c_pkg.sv -----
// Types, constants and the Windows-1252 lookup for the UTF-8 converter.
// Depends on nothing; used by u2c_in_stage, u2c_step and the top level.
package u2c_pkg;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_ENABLE      = 1'b0,
		REG_REPLACEMENT = 1'b1
	} reg_idx_t;

	localparam logic       ENABLE_RST      = 1'b1;
	localparam logic [7:0] REPLACEMENT_RST = 8'h3F;

	// Sequence sizes
	localparam logic [2:0] SEQ_NONE = 3'd0;
	localparam logic [2:0] SEQ_TWO  = 3'd2;
	localparam logic [2:0] SEQ_THREE = 3'd3;
	localparam logic [2:0] SEQ_FOUR = 3'd4;

	// One input beat
	typedef struct packed {
		logic [7:0] in_byte;
		logic       last;
	} item_t;

	// One result beat
	typedef struct packed {
		logic [7:0] ansi_byte;
		logic       has_byte;
		logic       invalid_string;
		logic       end_of_string;
	} result_t;

	// Configuration as seen by the datapath
	typedef struct packed {
		logic       enable;
		logic [7:0] replacement_byte;
	} cfg_t;

	// Map a completed sequence to its Windows-1252 byte
	function automatic logic [7:0] map_seq(logic [2:0] size, logic [23:0] code,
			logic [7:0] repl);
		logic [7:0] res;
		res = repl;
		if (size == SEQ_FOUR) begin
			res = repl;
		end else if (size == SEQ_TWO && code >= 24'hC2A0 && code <= 24'hC2BF) begin
			res = code[7:0];
		end else if (size == SEQ_TWO && code >= 24'hC380 && code <= 24'hC3BF) begin
			res = code[7:0] + 8'h40;
		end else begin
			case (code)
				24'hE282AC: res = 8'h80;
				24'hE2809A: res = 8'h82;
				24'h00C692: res = 8'h83;
				24'hE2809E: res = 8'h84;
				24'hE280A6: res = 8'h85;
				24'hE280A0: res = 8'h86;
				24'hE280A1: res = 8'h87;
				24'h00CB86: res = 8'h88;
				24'hE280B0: res = 8'h89;
				24'h00C5A0: res = 8'h8A;
				24'hE280B9: res = 8'h8B;
				24'h00C592: res = 8'h8C;
				24'h00C5BD: res = 8'h8E;
				24'hE28098: res = 8'h91;
				24'hE28099: res = 8'h92;
				24'hE2809C: res = 8'h93;
				24'hE2809D: res = 8'h94;
				24'hE280A2: res = 8'h95;
				24'hE28093: res = 8'h96;
				24'hE28094: res = 8'h97;
				24'h00CB9C: res = 8'h98;
				24'hE284A2: res = 8'h99;
				24'h00C5A1: res = 8'h9A;
				24'hE280BA: res = 8'h9B;
				24'h00C593: res = 8'h9C;
				24'h00C5BE: res = 8'h9E;
				24'h00C5B8: res = 8'h9F;
				default:    res = repl;
			endcase
		end
		return res;
	endfunction

endpackage

// ----- rtl/u2c_in_stage.sv -----
// Input register stage of the UTF-8 converter: captures one beat per cycle while the result register does not stall.
// Depends on u2c_pkg.
module u2c_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  u2c_pkg::item_t in_item,
	input  logic           advance,
	output logic           valid_s1,
	output u2c_pkg::item_t item_s1
);
	import u2c_pkg::*;

	// Take a new beat when the stage is empty or drains this cycle
	assign in_ready = !valid_s1 || advance;

	// Hold valid until the stage drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture payload on acceptance
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- rtl/u2c_step.sv -----
// Sequence decoder and result register of the UTF-8 converter.
// Depends on u2c_pkg (types, size constants, map_seq).
module u2c_step (
	input  logic             clk,
	input  logic             arst_n,
	input  u2c_pkg::cfg_t    cfg,
	input  logic             valid_s1,
	input  u2c_pkg::item_t   item_s1,
	output logic             advance,
	output logic             out_valid,
	input  logic             out_ready,
	output u2c_pkg::result_t result_s2
);
	import u2c_pkg::*;

	logic [2:0]  seq_size_q, seq_size_n;
	logic [1:0]  bytes_left_q, bytes_left_n;
	logic [23:0] seq_value_q, seq_value_n;
	logic        stopped_q, stopped_n;
	logic        failed_q, failed_n;
	logic        have;
	logic [7:0]  ch;
	logic        emit;
	logic        out_valid_s2;
	logic [7:0]  b;
	logic        run;
	logic [23:0] shifted;

	assign out_valid = out_valid_s2;
	assign advance   = !out_valid_s2 || out_ready;
	assign b         = item_s1.in_byte;
	assign run       = cfg.enable && !stopped_q && !failed_q;
	assign shifted   = {seq_value_q[15:0], b};

	// Decode one byte against the open sequence
	always_comb begin
		seq_size_n   = seq_size_q;
		bytes_left_n = bytes_left_q;
		seq_value_n  = seq_value_q;
		stopped_n    = stopped_q;
		failed_n     = failed_q;
		have         = 1'b0;
		ch           = 8'h00;
		if (run) begin
			if (bytes_left_q != 2'd0) begin
				seq_value_n  = shifted;
				bytes_left_n = bytes_left_q - 2'd1;
				if (bytes_left_q == 2'd1) begin
					ch          = map_seq(seq_size_q, shifted, cfg.replacement_byte);
					have        = 1'b1;
					seq_size_n  = SEQ_NONE;
					seq_value_n = 24'h000000;
				end
			end else if (b == 8'h00) begin
				stopped_n = 1'b1;
			end else if (!b[7]) begin
				ch   = b;
				have = 1'b1;
			end else if ((b & 8'hE0) == 8'hC0) begin
				seq_size_n   = SEQ_TWO;
				bytes_left_n = 2'd1;
				seq_value_n  = {16'h0000, b};
			end else if ((b & 8'hF0) == 8'hE0) begin
				seq_size_n   = SEQ_THREE;
				bytes_left_n = 2'd2;
				seq_value_n  = {16'h0000, b};
			end else if ((b & 8'hF8) == 8'hF0) begin
				seq_size_n   = SEQ_FOUR;
				bytes_left_n = 2'd3;
				seq_value_n  = {16'h0000, b};
			end else begin
				failed_n = 1'b1;
			end
		end
	end

	assign emit = have || item_s1.last;

	// Advance string state; drop it all after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_size_q   <= SEQ_NONE;
			bytes_left_q <= 2'd0;
			seq_value_q  <= 24'h000000;
			stopped_q    <= 1'b0;
			failed_q     <= 1'b0;
		end else if (valid_s1 && advance) begin
			if (item_s1.last) begin
				seq_size_q   <= SEQ_NONE;
				bytes_left_q <= 2'd0;
				seq_value_q  <= 24'h000000;
				stopped_q    <= 1'b0;
				failed_q     <= 1'b0;
			end else begin
				seq_size_q   <= seq_size_n;
				bytes_left_q <= bytes_left_n;
				seq_value_q  <= seq_value_n;
				stopped_q    <= stopped_n;
				failed_q     <= failed_n;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= valid_s1 && emit;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			result_s2.ansi_byte      <= have ? ch : 8'h00;
			result_s2.has_byte       <= have;
			result_s2.invalid_string <= cfg.enable && failed_n;
			result_s2.end_of_string  <= item_s1.last;
		end
	end

endmodule

// ----- rtl/utf8_to_cp1252_decoder.sv -----
// Top level of the UTF-8 to Windows-1252 converter: config registers and pipeline.
// Depends on u2c_pkg, u2c_in_stage and u2c_step.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one UTF-8 byte per beat, with
//    last set on the final byte of each string.
//  - Output channel (out_valid/out_ready) carries zero or one result per input
//    beat: a converted character, and always an end marker for a last byte.
//  - Configuration: cfg_we writes cfg_data to register cfg_index (0 enable,
//    1 replacement byte) at the clock edge; write only while the block is idle.
//  - Pipeline: an accepted byte passes the input register, then the result
//    register, which shows its result, if any, until out_ready takes it.
//  - Throughput: one byte per cycle unless out_ready stalls the output; the decode
//    step is a single pass of lookup logic between the input and result registers.
//  - Reset: arst_n clears both stages and the string state; enable returns to
//    1 and the replacement byte to '?'.
//  - Stall: while out_ready is low the result register holds, the input
//    register fills, and in_ready drops once both are occupied.
module utf8_to_cp1252_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] ansi_byte,
	output logic       has_byte,
	output logic       invalid_string,
	output logic       end_of_string,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import u2c_pkg::*;

	logic       enable_q;
	logic [7:0] replacement_q;
	cfg_t       cfg;
	item_t      in_item;
	item_t      item_s1;
	logic       valid_s1;
	logic       advance;
	result_t    result_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= ENABLE_RST;
			replacement_q <= REPLACEMENT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ENABLE:      enable_q      <= cfg_data[0];
				REG_REPLACEMENT: replacement_q <= cfg_data;
				default:         enable_q      <= enable_q;
			endcase
		end
	end

	assign cfg.enable           = enable_q;
	assign cfg.replacement_byte = replacement_q;

	assign in_item.in_byte = in_byte;
	assign in_item.last    = last;

	u2c_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	u2c_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_s2 (result_s2)
	);

	assign ansi_byte      = result_s2.ansi_byte;
	assign has_byte       = result_s2.has_byte;
	assign invalid_string = result_s2.invalid_string;
	assign end_of_string  = result_s2.end_of_string;

endmodule

// ----- rtl/u2c_checker.sv -----
// Port-level checks for the UTF-8 converter, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module u2c_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] ansi_byte,
	input logic       has_byte,
	input logic       invalid_string,
	input logic       end_of_string
);

	// Every result beat carries a character or an end marker
	`ASSERT_IMPLY(a_result_used, clk, arst_n, out_valid, has_byte || end_of_string)
	// No character means a zero byte
	`ASSERT_IMPLY(a_empty_zero, clk, arst_n, out_valid && !has_byte, ansi_byte == 8'h00)
	// Invalid flag only on an end marker without a character
	`ASSERT_IMPLY(a_invalid_end, clk, arst_n, out_valid && invalid_string,
		end_of_string && !has_byte)
	// Hold a stalled result
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(ansi_byte) && $stable(end_of_string))

endmodule

bind utf8_to_cp1252_decoder u2c_checker u_chk (.*);
